// ----- rtl/adsr_pkg.sv -----
// Shared types, widths and constants for the ADSR envelope step block.
package adsr_pkg;

   localparam int FRAC_BITS = 23;
   localparam int COEF_W    = 24;
   localparam int BASE_W    = 25;
   localparam int LEVEL_W   = 24;
   localparam int PHASE_W   = 3;
   localparam int SUM_W     = BASE_W + 2;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DW    = BASE_W;

   localparam longint ONE_VAL = longint'(1) << FRAC_BITS;

   localparam logic [LEVEL_W-1:0]      LEVEL_ONE = LEVEL_W'(ONE_VAL);
   // v <= 0.01 * ONE  <=>  v <= floor(ONE / 100)
   localparam logic signed [SUM_W-1:0] SNAP_LO   = SUM_W'(ONE_VAL / 100);
   // v >  0.99 * ONE  <=>  v >  floor(99 * ONE / 100)
   localparam logic signed [SUM_W-1:0] SNAP_HI   = SUM_W'((ONE_VAL * 99) / 100);

   // register indexes on the csr port
   localparam logic [CSR_IDX_W-1:0] CSR_ATTACK_COEF  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ATTACK_BASE  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DECAY_COEF   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_DECAY_BASE   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_RELEASE_COEF = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_RELEASE_BASE = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_SUSTAIN      = 3'd6;

   // phase codes as seen on the result word
   localparam logic [PHASE_W-1:0] PHASE_CODE_IDLE    = 3'd0;
   localparam logic [PHASE_W-1:0] PHASE_CODE_ATTACK  = 3'd1;
   localparam logic [PHASE_W-1:0] PHASE_CODE_DECAY   = 3'd2;
   localparam logic [PHASE_W-1:0] PHASE_CODE_SUSTAIN = 3'd3;
   localparam logic [PHASE_W-1:0] PHASE_CODE_RELEASE = 3'd4;

   typedef enum logic [4:0] {
      PH_IDLE    = 5'b00001,
      PH_ATTACK  = 5'b00010,
      PH_DECAY   = 5'b00100,
      PH_SUSTAIN = 5'b01000,
      PH_RELEASE = 5'b10000
   } phase_type;

   function automatic logic [PHASE_W-1:0] phase_code(input phase_type ph);
      logic [PHASE_W-1:0] code;
      case (ph)
         PH_ATTACK:  code = PHASE_CODE_ATTACK;
         PH_DECAY:   code = PHASE_CODE_DECAY;
         PH_SUSTAIN: code = PHASE_CODE_SUSTAIN;
         PH_RELEASE: code = PHASE_CODE_RELEASE;
         default:    code = PHASE_CODE_IDLE;
      endcase
      return code;
   endfunction

   // near-zero goes to zero, near-full goes to full scale
   function automatic logic [LEVEL_W-1:0] snap(input logic signed [SUM_W-1:0] v);
      logic [LEVEL_W-1:0] res;
      if (v <= SNAP_LO) begin
         res = '0;
      end else if (v > SNAP_HI) begin
         res = LEVEL_ONE;
      end else begin
         res = v[LEVEL_W-1:0];
      end
      return res;
   endfunction

endpackage

// ----- rtl/adsr_if.sv -----
// Valid/ready channel interfaces for the tick and result words.
interface adsr_req_if import adsr_pkg::*; ();
   logic valid;
   logic ready;
   logic gate_on;

   modport source (output valid, output gate_on, input ready);
   modport sink   (input valid, input gate_on, output ready);
endinterface

interface adsr_rsp_if import adsr_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [LEVEL_W-1:0] level;
   logic [PHASE_W-1:0] phase;

   modport source (output valid, output level, output phase, input ready);
   modport sink   (input valid, input level, input phase, output ready);
endinterface

// ----- rtl/adsr_envelope_step.sv -----
// Top level of the exponential ADSR envelope step block.
//
// Each word on req_chan is one sample tick carrying the gate; each tick gives
// exactly one result word on rsp_chan with the new envelope level (Q1.23,
// full scale 8388608) and phase (0 idle, 1 attack, 2 decay, 3 sustain,
// 4 release). Throughput is one tick per clock while req_chan.ready is high:
// the level register feeds a single 24x24 multiply, a 27-bit add and the snap
// compares straight back into itself, so that loop sets the clock period. The
// result and rsp_chan.valid are registered. A two-entry output stage (result
// register plus skid register) lets one more tick be taken while a result
// waits; req_chan.ready drops only when both are full. Coefficients, bases
// and the sustain level are written through the csr port (index 0..6 in the
// order attack_coef, attack_base, decay_coef, decay_base, release_coef,
// release_base, sustain_level; index 7 is ignored) and should only change
// while no tick is in flight. Reset zeroes all but output data; phase idle.
module adsr_envelope_step import adsr_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   adsr_req_if.sink             req_chan,
   adsr_rsp_if.source           rsp_chan,
   input  logic                 csr_wr_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_DW-1:0]    csr_wdata
);

   // ---- configuration registers ----
   logic        [COEF_W-1:0]  attack_coef_ff,  decay_coef_ff,  release_coef_ff;
   logic signed [BASE_W-1:0]  attack_base_ff,  decay_base_ff,  release_base_ff;
   logic        [LEVEL_W-1:0] sustain_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         attack_coef_ff  <= '0;
         attack_base_ff  <= '0;
         decay_coef_ff   <= '0;
         decay_base_ff   <= '0;
         release_coef_ff <= '0;
         release_base_ff <= '0;
         sustain_ff      <= '0;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_ATTACK_COEF:  attack_coef_ff  <= csr_wdata[COEF_W-1:0];
            CSR_ATTACK_BASE:  attack_base_ff  <= $signed(csr_wdata[BASE_W-1:0]);
            CSR_DECAY_COEF:   decay_coef_ff   <= csr_wdata[COEF_W-1:0];
            CSR_DECAY_BASE:   decay_base_ff   <= $signed(csr_wdata[BASE_W-1:0]);
            CSR_RELEASE_COEF: release_coef_ff <= csr_wdata[COEF_W-1:0];
            CSR_RELEASE_BASE: release_base_ff <= $signed(csr_wdata[BASE_W-1:0]);
            CSR_SUSTAIN:      sustain_ff      <= csr_wdata[LEVEL_W-1:0];
            default: ;
         endcase
      end
   end

   // ---- envelope state ----
   phase_type          phase_ff, phase_in;
   logic [LEVEL_W-1:0] level_ff, level_in;

   logic accept;
   logic skid_valid_ff;

   assign req_chan.ready = !skid_valid_ff;
   assign accept         = req_chan.valid && req_chan.ready;

   // pick the segment's multiplier and offset
   logic        [COEF_W-1:0] coef_sel;
   logic signed [BASE_W-1:0] base_sel;

   always_comb begin
      case (phase_ff)
         PH_ATTACK: begin
            coef_sel = attack_coef_ff;
            base_sel = attack_base_ff;
         end
         PH_DECAY: begin
            coef_sel = decay_coef_ff;
            base_sel = decay_base_ff;
         end
         default: begin
            coef_sel = release_coef_ff;
            base_sel = release_base_ff;
         end
      endcase
   end

   // base + (level * coef) >> 24, then snapped
   logic [LEVEL_W+COEF_W-1:0] prod_full;
   logic [LEVEL_W-1:0]        prod;
   logic signed [SUM_W-1:0]   sum;
   logic [LEVEL_W-1:0]        stepped;
   logic [LEVEL_W-1:0]        sustain_snap;

   assign prod_full    = (LEVEL_W+COEF_W)'(level_ff) * (LEVEL_W+COEF_W)'(coef_sel);
   assign prod         = prod_full[LEVEL_W+COEF_W-1:COEF_W];
   assign sum          = SUM_W'(base_sel) + $signed({(SUM_W-LEVEL_W)'(1'b0), prod});
   assign stepped      = snap(sum);
   assign sustain_snap = snap($signed({(SUM_W-LEVEL_W)'(1'b0), sustain_ff}));

   always_comb begin
      phase_in = phase_ff;
      level_in = level_ff;
      case (phase_ff)
         PH_ATTACK: begin
            level_in = stepped;
            phase_in = PH_ATTACK;
            if (stepped >= LEVEL_ONE) begin
               level_in = LEVEL_ONE;
               phase_in = PH_DECAY;
            end
            if (!req_chan.gate_on) phase_in = PH_RELEASE;
         end
         PH_DECAY: begin
            level_in = stepped;
            if (stepped <= sustain_ff) begin
               level_in = sustain_snap;
               phase_in = PH_SUSTAIN;
            end
            if (!req_chan.gate_on) phase_in = PH_RELEASE;
         end
         PH_SUSTAIN: begin
            if (!req_chan.gate_on) phase_in = PH_RELEASE;
         end
         PH_RELEASE: begin
            level_in = stepped;
            if (stepped == '0) phase_in = PH_IDLE;
            if (req_chan.gate_on) phase_in = PH_ATTACK;
         end
         default: begin
            // idle: level untouched this tick
            phase_in = req_chan.gate_on ? PH_ATTACK : PH_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         level_ff <= '0;
      end else if (accept) begin
         phase_ff <= phase_in;
         level_ff <= level_in;
      end
   end

   // ---- result register + skid register ----
   logic               rsp_valid_ff;
   logic [LEVEL_W-1:0] rsp_level_ff, skid_level_ff;
   logic [PHASE_W-1:0] rsp_phase_ff, skid_phase_ff;
   logic               pop;

   assign pop = rsp_valid_ff && rsp_chan.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (!rsp_valid_ff || pop) begin
         if (skid_valid_ff) begin
            rsp_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end else begin
            rsp_valid_ff  <= accept;
         end
      end else if (accept) begin
         // result still held downstream: park the new word
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (!rsp_valid_ff || pop) begin
         if (skid_valid_ff) begin
            rsp_level_ff <= skid_level_ff;
            rsp_phase_ff <= skid_phase_ff;
         end else begin
            rsp_level_ff <= level_in;
            rsp_phase_ff <= phase_code(phase_in);
         end
      end else if (accept) begin
         skid_level_ff <= level_in;
         skid_phase_ff <= phase_code(phase_in);
      end
   end

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.level = rsp_level_ff;
   assign rsp_chan.phase = rsp_phase_ff;

endmodule
